>>> rtl/core/cta_pkg.sv
// cta_pkg: shared types, constants and calendar helpers for the calendar time adder.
// No dependencies. Used by the channel interfaces and calendar_time_add_seconds.
package cta_pkg;

   localparam int unsigned SECS_PER_MIN  = 60;
   localparam int unsigned SECS_PER_HOUR = 60 * 60;
   localparam int unsigned SECS_PER_DAY  = 24 * 60 * 60;
   localparam int unsigned DAYS_PER_YEAR = 365;
   localparam int unsigned DAYS_PER_QUAD = 4 * 365 + 1;
   // 2000..2099: every fourth year is leap, 2000 included
   localparam int unsigned SPAN_DAYS     = 100 * 365 + 25;
   localparam longint unsigned SPAN_SECS = 64'(SPAN_DAYS) * 64'(SECS_PER_DAY);
   localparam int unsigned YEAR_LAST     = 99;
   localparam int unsigned QUAD_LAST     = 96;
   localparam int unsigned MONTH_LAST    = 12;
   localparam int unsigned CENTURY_YEAR  = 100;

   // Quotient widths of the three divisions done on the shared multiplier
   localparam int unsigned DAY_Q_BITS  = 16;
   localparam int unsigned HOUR_Q_BITS = 5;
   localparam int unsigned MIN_Q_BITS  = 6;

   // Shared multiplier operand and product widths
   localparam int unsigned MUL_W  = 26;
   localparam int unsigned PROD_W = 2 * MUL_W;

   // Reciprocal division: q = ((x >> PRE) * RECIP) >> SHIFT, exact over each step's range
   localparam int unsigned DAY_PRE_SHIFT  = 7;
   localparam int unsigned DAY_RECIP      = 50903317;  // ceil(2^35 / 675)
   localparam int unsigned DAY_SHIFT      = 35;
   localparam int unsigned HOUR_PRE_SHIFT = 4;
   localparam int unsigned HOUR_RECIP     = 9321;      // ceil(2^21 / 225)
   localparam int unsigned HOUR_SHIFT     = 21;
   localparam int unsigned MIN_PRE_SHIFT  = 2;
   localparam int unsigned MIN_RECIP      = 1093;      // ceil(2^14 / 15)
   localparam int unsigned MIN_SHIFT      = 14;

   // Signed working accumulator: covers every linear time plus delta
   localparam int unsigned ACC_W = 35;

   typedef struct packed {
      logic [6:0]         in_year;
      logic [3:0]         in_month;
      logic [4:0]         in_day;
      logic [4:0]         in_hour;
      logic [5:0]         in_minute;
      logic [5:0]         in_second;
      logic signed [31:0] delta_seconds;
   } req_type;

   typedef struct packed {
      logic [6:0] out_year;
      logic [3:0] out_month;
      logic [4:0] out_day;
      logic [4:0] out_hour;
      logic [5:0] out_minute;
      logic [5:0] out_second;
      logic       range_error;
   } rsp_type;

   // Gregorian rule over 2000..2127: 2100 is the only multiple of four that is not leap
   function automatic logic is_leap(input logic [6:0] y);
      return (y[1:0] == 2'b00) && (y != 7'(CENTURY_YEAR));
   endfunction

   // 13..15 continue the August pattern (30, 31, 30)
   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      if (m == 4'd2) begin
         len = leap ? 5'd29 : 5'd28;
      end else if (m <= 4'd7) begin
         len = m[0] ? 5'd31 : 5'd30;
      end else begin
         len = m[0] ? 5'd30 : 5'd31;
      end
      return len;
   endfunction

   // Days in the years 0 .. y-1
   function automatic logic [15:0] year_base(input logic [6:0] y);
      logic [16:0] plain;
      logic [7:0]  leaps;
      plain = 17'(y) * 17'(DAYS_PER_YEAR);
      leaps = ({1'b0, y} + 8'd3) >> 2;
      if (y > 7'(CENTURY_YEAR)) begin
         leaps = leaps - 8'd1;
      end
      return 16'(plain + 17'(leaps));
   endfunction

endpackage

>>> rtl/core/cta_req_if.sv
// cta_req_if: request channel (valid/ready plus calendar time and delta payload).
// Depends on cta_pkg.
interface cta_req_if
   import cta_pkg::*;
();
   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/core/cta_rsp_if.sv
// cta_rsp_if: response channel (valid/ready plus normalized calendar time payload).
// Depends on cta_pkg.
interface cta_rsp_if
   import cta_pkg::*;
();
   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/core/calendar_time_add_seconds.sv
// calendar_time_add_seconds: adds a signed second count to a 2000..2099 calendar time.
// Depends on cta_pkg, cta_req_if and cta_rsp_if.
//
//   channel   dir  handshake      beat contents
//   req_chan  in   valid/ready    year, month, day, hour, minute, second, delta_seconds
//   rsp_chan  out  valid/ready    year, month, day, hour, minute, second, range_error
//
// One beat at a time, run by a sequencer over one shared 35-bit add/compare unit and one
// 26x26 multiplier: accept, month sum (up to 14 adds), five setup steps, six reciprocal
// divide steps, up to 24 four-year, 3 year and 11 month steps; each loop adds one closing
// check. The result is valid the cycle after the final step.
// Synchronous active-high reset returns to idle with no result pending. A result waits
// in the output register; only the next request's final step stalls while it is unread.
module calendar_time_add_seconds
   import cta_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   cta_req_if.sink    req_chan,
   cta_rsp_if.source  rsp_chan
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_MON,     // linear: add lengths of months before the input month
      S_DAY,     // linear: add day of month
      S_MUL,     // linear: days to seconds
      S_HMS,     // linear: add hh:mm:ss, less the day counted by "day" instead of "day-1"
      S_DELTA,   // add the signed delta
      S_CLAMP,   // saturate to 2000..2099
      S_QDAY,    // day count by reciprocal multiply
      S_RDAY,    // seconds left in the day
      S_QHOUR,   // hour by reciprocal multiply
      S_RHOUR,   // seconds left in the hour
      S_QMIN,    // minute by reciprocal multiply
      S_RMIN,    // seconds left in the minute
      S_YEAR4,   // strip whole four-year groups
      S_YEAR1,   // strip single years
      S_MON2     // strip months, then hand off the result
   } state_type;

   state_type           state_ff,   state_in;
   req_type             req_ff,     req_in;
   rsp_type             rsp_ff,     rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ACC_W-1:0]    acc_ff,     acc_in;
   logic [DAY_Q_BITS-1:0] days_ff,  days_in;
   logic [6:0]          year_ff,    year_in;
   logic [3:0]          mon_ff,     mon_in;
   logic [4:0]          hour_ff,    hour_in;
   logic [5:0]          minute_ff,  minute_in;
   logic [5:0]          second_ff,  second_in;
   logic                err_ff,     err_in;

   // shared unit
   logic [ACC_W-1:0]      addend;
   logic [ACC_W-1:0]      sum;
   logic                  ge;
   logic [16:0]           hms_secs;
   logic [MUL_W-1:0]      mul_a;
   logic [MUL_W-1:0]      mul_b;
   logic [PROD_W-1:0]     prod;
   logic                  rsp_free;

   assign req_chan.ready   = (state_ff == S_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   assign hms_secs = 17'(req_ff.in_hour) * 17'(SECS_PER_HOUR)
                   + 17'(req_ff.in_minute) * 17'(SECS_PER_MIN)
                   + 17'(req_ff.in_second);

   // Shared multiplier: days to seconds, reciprocal quotients and quotient times divisor
   always_comb begin
      unique case (state_ff)
         S_MUL: begin
            mul_a = MUL_W'(acc_ff[DAY_Q_BITS-1:0]);
            mul_b = MUL_W'(SECS_PER_DAY);
         end
         S_QDAY: begin
            mul_a = MUL_W'(acc_ff[31:DAY_PRE_SHIFT]);
            mul_b = MUL_W'(DAY_RECIP);
         end
         S_RDAY: begin
            mul_a = MUL_W'(days_ff);
            mul_b = MUL_W'(SECS_PER_DAY);
         end
         S_QHOUR: begin
            mul_a = MUL_W'(acc_ff[16:HOUR_PRE_SHIFT]);
            mul_b = MUL_W'(HOUR_RECIP);
         end
         S_RHOUR: begin
            mul_a = MUL_W'(hour_ff);
            mul_b = MUL_W'(SECS_PER_HOUR);
         end
         S_QMIN: begin
            mul_a = MUL_W'(acc_ff[11:MIN_PRE_SHIFT]);
            mul_b = MUL_W'(MIN_RECIP);
         end
         S_RMIN: begin
            mul_a = MUL_W'(minute_ff);
            mul_b = MUL_W'(SECS_PER_MIN);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

   // Operand of the shared adder; subtraction feeds the negated operand and
   // the sign of the sum is the compare result.
   always_comb begin
      unique case (state_ff)
         S_MON:   addend = ACC_W'(month_len(mon_ff, is_leap(req_ff.in_year)));
         S_DAY:   addend = ACC_W'(req_ff.in_day);
         S_HMS:   addend = ACC_W'(hms_secs) - ACC_W'(SECS_PER_DAY);
         S_DELTA: addend = {{(ACC_W-32){req_ff.delta_seconds[31]}}, req_ff.delta_seconds};
         S_CLAMP: addend = -ACC_W'(SPAN_SECS);
         S_RDAY:  addend = -ACC_W'(prod);
         S_RHOUR: addend = -ACC_W'(prod);
         S_RMIN:  addend = -ACC_W'(prod);
         S_YEAR4: addend = -ACC_W'(DAYS_PER_QUAD);
         S_YEAR1: addend = -ACC_W'(is_leap(year_ff) ? DAYS_PER_YEAR + 1 : DAYS_PER_YEAR);
         S_MON2:  addend = -ACC_W'(month_len(mon_ff, is_leap(year_ff)));
         default: addend = '0;
      endcase
   end

   assign sum      = acc_ff + addend;
   assign ge       = ~sum[ACC_W-1];
   assign rsp_free = ~rsp_valid_ff | rsp_chan.ready;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_chan.ready;
      acc_in       = acc_ff;
      days_in      = days_ff;
      year_in      = year_ff;
      mon_in       = mon_ff;
      hour_in      = hour_ff;
      minute_in    = minute_ff;
      second_in    = second_ff;
      err_in       = err_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               req_in   = req_chan.payload;
               acc_in   = ACC_W'(year_base(req_chan.payload.in_year));
               mon_in   = 4'd1;
               err_in   = 1'b0;
               state_in = S_MON;
            end
         end
         S_MON: begin
            if (mon_ff < req_ff.in_month) begin
               acc_in = sum;
               mon_in = mon_ff + 4'd1;
            end else begin
               state_in = S_DAY;
            end
         end
         S_DAY: begin
            acc_in   = sum;
            state_in = S_MUL;
         end
         S_MUL: begin
            acc_in   = ACC_W'(prod);
            state_in = S_HMS;
         end
         S_HMS: begin
            acc_in   = sum;
            state_in = S_DELTA;
         end
         S_DELTA: begin
            acc_in   = sum;
            state_in = S_CLAMP;
         end
         S_CLAMP: begin
            if (acc_ff[ACC_W-1]) begin
               acc_in = '0;
               err_in = 1'b1;
            end else if (ge) begin
               acc_in = ACC_W'(SPAN_SECS - 64'd1);
               err_in = 1'b1;
            end
            state_in = S_QDAY;
         end
         S_QDAY: begin
            days_in  = prod[DAY_SHIFT +: DAY_Q_BITS];
            state_in = S_RDAY;
         end
         S_RDAY: begin
            acc_in   = sum;
            state_in = S_QHOUR;
         end
         S_QHOUR: begin
            hour_in  = prod[HOUR_SHIFT +: HOUR_Q_BITS];
            state_in = S_RHOUR;
         end
         S_RHOUR: begin
            acc_in   = sum;
            state_in = S_QMIN;
         end
         S_QMIN: begin
            minute_in = prod[MIN_SHIFT +: MIN_Q_BITS];
            state_in  = S_RMIN;
         end
         S_RMIN: begin
            second_in = sum[5:0];
            acc_in    = ACC_W'(days_ff);
            year_in   = '0;
            state_in  = S_YEAR4;
         end
         S_YEAR4: begin
            if ((year_ff < 7'(QUAD_LAST)) && ge) begin
               acc_in  = sum;
               year_in = year_ff + 7'd4;
            end else begin
               state_in = S_YEAR1;
            end
         end
         S_YEAR1: begin
            if ((year_ff < 7'(YEAR_LAST)) && ge) begin
               acc_in  = sum;
               year_in = year_ff + 7'd1;
            end else begin
               mon_in   = 4'd1;
               state_in = S_MON2;
            end
         end
         S_MON2: begin
            if ((mon_ff < 4'(MONTH_LAST)) && ge) begin
               acc_in = sum;
               mon_in = mon_ff + 4'd1;
            end else if (rsp_free) begin
               // final step stalls only while the previous beat is unread
               rsp_in.out_year    = year_ff;
               rsp_in.out_month   = mon_ff;
               rsp_in.out_day     = acc_ff[4:0] + 5'd1;
               rsp_in.out_hour    = hour_ff;
               rsp_in.out_minute  = minute_ff;
               rsp_in.out_second  = second_ff;
               rsp_in.range_error = err_ff;
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff    <= req_in;
      rsp_ff    <= rsp_in;
      acc_ff    <= acc_in;
      days_ff   <= days_in;
      year_ff   <= year_in;
      mon_ff    <= mon_in;
      hour_ff   <= hour_in;
      minute_ff <= minute_in;
      second_ff <= second_in;
      err_ff    <= err_in;
   end

endmodule

>>> dv/calendar_time_add_seconds_tb.sv
`timescale 1ns / 1ps
// calendar_time_add_seconds_tb: self-checking bench for the calendar time adder.
// Depends on cta_pkg, cta_req_if, cta_rsp_if and calendar_time_add_seconds.

import cta_pkg::*;

localparam longint DAY_SECS  = 24 * 60 * 60;
localparam int     DELTA_MIN = 32'sh8000_0000;
localparam int     DELTA_MAX = 32'sh7fff_ffff;

// Scoreboard: predicts the sum for every accepted request beat and checks
// result beats against the oldest prediction, in order.
class time_sum_board;
   rsp_type     due_times[$];
   int unsigned mismatches;

   function new();
      mismatches = 0;
   endfunction

   function bit leap_year(int y);
      int full;
      full = y + 2000;
      return ((full % 4) == 0 && (full % 100) != 0) || (full % 400) == 0;
   endfunction

   function int year_length(int y);
      return leap_year(y) ? 366 : 365;
   endfunction

   // 13..15 run on with the August pattern
   function int month_length(int m, int y);
      if (m == 2) begin
         return leap_year(y) ? 29 : 28;
      end
      if (m <= 7) begin
         return (m % 2 == 0) ? 30 : 31;
      end
      return (m % 2 == 1) ? 30 : 31;
   endfunction

   // Seconds since 2000-01-01 00:00:00, every field taken at face value
   function longint linear_seconds(req_type r);
      longint days;
      int     yr;
      int     mo;
      days = 0;
      for (yr = 0; yr < int'(r.in_year); yr++) begin
         days += year_length(yr);
      end
      for (mo = 1; mo < int'(r.in_month); mo++) begin
         days += month_length(mo, int'(r.in_year));
      end
      days += longint'(r.in_day) - 1;
      return days * DAY_SECS + longint'(r.in_hour) * 3600
           + longint'(r.in_minute) * 60 + longint'(r.in_second);
   endfunction

   function longint span_seconds();
      longint span_days;
      int     yr;
      span_days = 0;
      for (yr = 0; yr < 100; yr++) begin
         span_days += year_length(yr);
      end
      return span_days * DAY_SECS;
   endfunction

   function rsp_type shift_calendar_time(req_type r);
      longint  total;
      longint  days;
      longint  secs;
      int      yr;
      int      mo;
      rsp_type o;
      total = linear_seconds(r) + longint'($signed(r.delta_seconds));
      o.range_error = 1'b0;
      if (total < 0) begin
         total = 0;
         o.range_error = 1'b1;
      end else if (total >= span_seconds()) begin
         total = span_seconds() - 1;
         o.range_error = 1'b1;
      end
      days = total / DAY_SECS;
      secs = total % DAY_SECS;
      yr = 0;
      while (yr < 99 && days >= year_length(yr)) begin
         days -= year_length(yr);
         yr++;
      end
      mo = 1;
      while (mo < 12 && days >= month_length(mo, yr)) begin
         days -= month_length(mo, yr);
         mo++;
      end
      o.out_year   = 7'(yr);
      o.out_month  = 4'(mo);
      o.out_day    = 5'(days + 1);
      o.out_hour   = 5'(secs / 3600);
      o.out_minute = 6'((secs / 60) % 60);
      o.out_second = 6'(secs % 60);
      return o;
   endfunction

   function void note_request(req_type r);
      due_times.push_back(shift_calendar_time(r));
   endfunction

   function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endfunction

   function void check_result(rsp_type got);
      rsp_type want;
      if (due_times.size() == 0) begin
         $error("result beat with no request pending");
         mismatches++;
         return;
      end
      want = due_times.pop_front();
      compare_field("out_year", want.out_year, got.out_year);
      compare_field("out_month", want.out_month, got.out_month);
      compare_field("out_day", want.out_day, got.out_day);
      compare_field("out_hour", want.out_hour, got.out_hour);
      compare_field("out_minute", want.out_minute, got.out_minute);
      compare_field("out_second", want.out_second, got.out_second);
      compare_field("range_error", want.range_error, got.range_error);
   endfunction

   function int outstanding();
      return due_times.size();
   endfunction
endclass

module calendar_time_add_seconds_tb;

   localparam int RANDOM_BEATS = 500;
   localparam int LONG_HOLD    = 500;   // receiver hold-off, well past two requests' work
   localparam int DRAIN_CYCLES = 120;   // well over the worst per-request latency

   logic clock;
   logic reset;

   cta_req_if req_chan();
   cta_rsp_if rsp_chan();

   calendar_time_add_seconds u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   time_sum_board board = new();

   // Handshake from the main process to the receiver: request one long hold-off
   bit hold_rsp_req = 1'b0;
   // Beats left in the current sender burst
   int burst_left   = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Monitor: both channels are sampled at the rising edge, so every value
   // seen here is the one that was stable before the edge.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            board.note_request(req_chan.payload);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            board.check_result(rsp_chan.payload);
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver: ready changes on the falling edge. It walks through stretches
   // of different stall patterns; a hold-off request from the main process
   // drops ready for the LONG_HOLD hold-off, counted here.
   // ------------------------------------------------------------------
   initial begin
      int unsigned mode;
      int unsigned stretch;
      int unsigned phase;
      rsp_chan.ready = 1'b0;
      phase = 0;
      wait (!reset);
      forever begin
         mode    = $urandom_range(0, 4);
         stretch = $urandom_range(10, 120);
         repeat (stretch) begin
            @(negedge clock);
            phase++;
            if (hold_rsp_req) begin
               hold_rsp_req = 1'b0;
               rsp_chan.ready <= 1'b0;
               repeat (LONG_HOLD - 1) @(negedge clock);
            end else begin
               case (mode)
                  0: rsp_chan.ready <= 1'b1;                              // no stalls
                  1: rsp_chan.ready <= ($urandom_range(0, 99) < 70);
                  2: rsp_chan.ready <= ($urandom_range(0, 99) < 25);
                  3: rsp_chan.ready <= phase[1];                          // follows phase bit 1
                  default: rsp_chan.ready <= ($urandom_range(0, 15) == 0);
               endcase
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Sender tasks: payload and valid change on the falling edge.
   // ------------------------------------------------------------------
   task automatic pause_sender(input int unsigned cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
      end
   endtask

   // Offers one beat and returns after the edge that takes it. Bursts of
   // random length are split by random gaps; half the bursts follow on at once.
   task automatic send_time(input req_type r);
      if (burst_left == 0) begin
         pause_sender($urandom_range(0, 1) ? 0 : $urandom_range(1, 15));
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      @(negedge clock);
      req_chan.valid   <= 1'b1;
      req_chan.payload <= r;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Drop valid, then wait at falling edges (after the monitor ran) until
   // every predicted result has come back.
   task automatic wait_for_results();
      pause_sender(1);
      while (board.outstanding() != 0) @(negedge clock);
   endtask

   function automatic req_type make_time(input int unsigned y, input int unsigned mo,
                                         input int unsigned d, input int unsigned h,
                                         input int unsigned mi, input int unsigned s,
                                         input int delta);
      req_type r;
      r.in_year       = 7'(y);
      r.in_month      = 4'(mo);
      r.in_day        = 5'(d);
      r.in_hour       = 5'(h);
      r.in_minute     = 6'(mi);
      r.in_second     = 6'(s);
      r.delta_seconds = delta;
      return r;
   endfunction

   // Mostly well-formed times with deltas of several sizes, aimed at day,
   // month, year and range edges; the rest is raw bits in every field.
   function automatic req_type random_time();
      req_type     r;
      int unsigned pick;
      longint      target;
      pick = $urandom_range(0, 99);
      if (pick >= 88) begin
         r = make_time($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom);
         return r;
      end
      r = make_time($urandom_range(0, 99), $urandom_range(1, 12), 1,
                    $urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59),
                    0);
      // near the range ends keep the distance within a 32-bit delta
      if (pick >= 70 && pick < 80) begin
         r.in_year = (pick < 75) ? 7'($urandom_range(0, 40)) : 7'($urandom_range(60, 99));
      end
      r.in_day = 5'($urandom_range(1, board.month_length(int'(r.in_month),
                                                         int'(r.in_year))));
      if (pick < 30) begin
         r.delta_seconds = int'($urandom_range(0, 200_000)) - 100_000;
      end else if (pick < 50) begin
         r.delta_seconds = int'($urandom_range(0, 80_000_000)) - 40_000_000;
      end else if (pick < 62) begin
         r.delta_seconds = $urandom;
      end else if (pick < 70) begin
         // whole days give or take up to three seconds: lands next to the same time of day
         r.delta_seconds = 32'((longint'($urandom_range(0, 800)) - 400) * DAY_SECS
                               + longint'($urandom_range(0, 6)) - 3);
      end else begin
         // a few seconds either side of the first or the last second of the span
         target = (pick < 75) ? 0 : board.span_seconds() - 1;
         target = target + longint'($urandom_range(0, 6)) - 3;
         r.delta_seconds = 32'(target - board.linear_seconds(r));
      end
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      int n;
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: range ends, leap days, saturation both ways, extreme deltas
      // and out-of-range fields taken at face value.
      send_time(make_time(0, 1, 1, 0, 0, 0, 0));
      send_time(make_time(99, 12, 31, 23, 59, 59, 0));
      send_time(make_time(99, 12, 31, 23, 59, 59, 1));           // saturates high
      send_time(make_time(0, 1, 1, 0, 0, 0, -1));                // saturates low
      send_time(make_time(0, 2, 28, 23, 59, 59, 1));             // into Feb 29 2000
      send_time(make_time(0, 2, 29, 0, 0, 0, 86_400));           // leap day to Mar 1
      send_time(make_time(1, 2, 28, 23, 59, 59, 1));             // plain year: Mar 1
      send_time(make_time(4, 3, 1, 0, 0, 0, -1));                // back to Feb 29
      send_time(make_time(0, 1, 1, 0, 0, 0, DELTA_MAX));
      send_time(make_time(99, 12, 31, 23, 59, 59, DELTA_MIN));
      send_time(make_time(0, 1, 1, 0, 0, 0, DELTA_MIN));
      send_time(make_time(99, 1, 1, 0, 0, 0, DELTA_MAX));
      send_time(make_time(127, 15, 31, 31, 63, 63, DELTA_MIN));  // all fields at max
      send_time(make_time(100, 1, 1, 0, 0, 0, -86_400));         // 2100 counts, not leap
      send_time(make_time(5, 0, 0, 0, 0, 0, 0));                 // month zero, day zero
      send_time(make_time(10, 13, 1, 0, 0, 0, 0));               // month past December
      send_time(make_time(10, 15, 31, 0, 0, 0, 0));
      send_time(make_time(50, 6, 15, 31, 63, 63, 0));            // oversized h/m/s
      send_time(make_time(98, 12, 31, 23, 59, 59, 1));           // into the last year
      send_time(make_time(96, 2, 29, 12, 0, 0, 31_536_000));
      send_time(make_time(0, 12, 31, 23, 59, 59, 1));
      send_time(make_time(0, 0, 0, 0, 0, 0, 0));                 // one day early: low
      send_time(make_time(127, 0, 0, 0, 0, 0, DELTA_MIN));
      send_time(make_time(0, 1, 1, 0, 0, 0, 1));
      wait_for_results();

      for (n = 0; n < RANDOM_BEATS; n++) begin
         // receiver holds off while beats keep coming: the block backs up
         if (n == 120) begin
            hold_rsp_req = 1'b1;
         end
         // sender stops until the pipe is empty
         if (n == 320) begin
            wait_for_results();
         end
         send_time(random_time());
      end

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog: worst case is ~550 beats, each with its sender gap, sequencer steps and
   // receiver stalls, plus the long hold-off; this allows several times that.
   initial begin
      #4_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
